/* rtl/core/stop_and_wait_transport_defines.svh */
// Assertion macros for the RTL of the transport endpoint; the queue uses them.
// Each macro checks a property on the rising edge of clk_i outside reset.
`ifndef STOP_AND_WAIT_TRANSPORT_DEFINES_SVH
`define STOP_AND_WAIT_TRANSPORT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SWT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SWT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/swt_pkg.sv */
`timescale 1ns / 1ps

package swt_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int LIM_W = (QCNT_W > 6) ? QCNT_W : 6;

  typedef logic [QPTR_W-1:0] ptr_t;
  typedef logic [QCNT_W-1:0] cnt_t;
  typedef logic [LIM_W-1:0] lim_t;

  localparam ptr_t QPTR_LAST = ptr_t'(QUEUE_DEPTH - 1);
  localparam cnt_t QCNT_FULL = cnt_t'(QUEUE_DEPTH);
  localparam lim_t QLIM_DEPTH = lim_t'(QUEUE_DEPTH);

  localparam logic [7:0] RST_ADDR_HIGH = 8'd255;
  localparam logic [15:0] RST_TIMEOUT = 16'd300;
  localparam logic [5:0] RST_QUEUE_LIMIT = 6'h3F;
  localparam logic [15:0] RST_ACK_BITS = 16'd1;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_SEND  = 2'd1,
    OP_FRAME = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    KIND_DATA    = 2'd0,
    KIND_ACK     = 2'd1,
    KIND_DELIVER = 2'd2,
    KIND_DROP    = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    DROP_NONE       = 3'd0,
    DROP_QUEUE_FULL = 3'd1,
    DROP_BAD_DEST   = 3'd2,
    DROP_NO_PAYLOAD = 3'd3,
    DROP_BIT_ERROR  = 3'd4,
    DROP_NOT_OURS   = 3'd5,
    DROP_BAD_OWN    = 3'd6
  } drop_e;

  typedef enum logic [2:0] {
    CFG_OWN_ADDR      = 3'd0,
    CFG_ADDR_LOW      = 3'd1,
    CFG_ADDR_HIGH     = 3'd2,
    CFG_TIMEOUT_TICKS = 3'd3,
    CFG_QUEUE_LIMIT   = 3'd4,
    CFG_HEADER_BITS   = 3'd5,
    CFG_ACK_BITS      = 3'd6,
    CFG_UP_CONNECTED  = 3'd7
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ITEM_DROP = 2'd0,
    ITEM_DATA = 2'd1,
    ITEM_ACK  = 2'd2
  } item_e;

  typedef struct packed {
    logic [7:0]  own_addr;
    logic [7:0]  addr_low;
    logic [7:0]  addr_high;
    logic [15:0] timeout_ticks;
    logic [5:0]  queue_limit;
    logic [15:0] header_bits;
    logic [15:0] ack_bits;
    logic        up_connected;
  } cfg_t;

  typedef struct packed {
    logic [7:0]  dst;
    logic [31:0] payload;
  } entry_t;

  typedef struct packed {
    logic   push;
    logic   pop;
    entry_t wdata;
  } qreq_t;

  typedef struct packed {
    cnt_t   count;
    entry_t rdata;
  } qstat_t;

  typedef struct packed {
    item_e       code;
    drop_e       reason;
    logic        deliver;
    logic [7:0]  src;
    logic [15:0] seq;
    logic [31:0] payload;
  } item_t;

  typedef struct packed {
    logic [15:0] send_seq;
    logic [15:0] expect_seq;
    entry_t      last;
  } view_t;

  typedef struct packed {
    kind_e       kind;
    logic [15:0] seq;
    logic [7:0]  src;
    logic [7:0]  dst;
    logic [3:0]  hop;
    logic [31:0] payload;
    logic [15:0] bits;
    drop_e       reason;
    logic        last;
  } result_t;

  // Remainder by ten through a reciprocal multiply, exact for 8-bit values.
  function automatic logic [3:0] mod10(input logic [7:0] x);
    logic [15:0] prod;
    logic [7:0]  quot;
    logic [7:0]  tens;
    logic [7:0]  rem;
    prod = {8'd0, x} * 16'd205;
    quot = {3'd0, prod[15:11]};
    tens = quot * 8'd10;
    rem  = x - tens;
    return rem[3:0];
  endfunction

endpackage

/* rtl/core/swt_queue.sv */
`timescale 1ns / 1ps
`include "stop_and_wait_transport_defines.svh"

module swt_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  swt_pkg::qreq_t      qreq_i,
  output swt_pkg::qstat_t     qstat_o
);

  swt_pkg::entry_t mem_q [swt_pkg::QUEUE_DEPTH];
  swt_pkg::entry_t rdata_q;
  swt_pkg::ptr_t   head_q, head_d;
  swt_pkg::ptr_t   tail_q, tail_d;
  swt_pkg::cnt_t   count_q, count_d;

  always_ff @(posedge clk_i) begin
    if (qreq_i.push) begin
      mem_q[tail_q] <= qreq_i.wdata;
    end
    if (qreq_i.pop) begin
      rdata_q <= mem_q[head_q];
    end
  end

  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    count_d = count_q;
    if (qreq_i.push) begin
      tail_d  = (tail_q == swt_pkg::QPTR_LAST) ? '0 : tail_q + 1'b1;
      count_d = count_q + 1'b1;
    end else if (qreq_i.pop) begin
      head_d  = (head_q == swt_pkg::QPTR_LAST) ? '0 : head_q + 1'b1;
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
    end
  end

  assign qstat_o.count = count_q;
  assign qstat_o.rdata = rdata_q;

  `SWT_ASSERT_NOW(a_push_room, qreq_i.push, count_q < swt_pkg::QCNT_FULL, "push into full queue")
  `SWT_ASSERT_NOW(a_pop_nonempty, qreq_i.pop, count_q != '0, "pop from empty queue")
  `SWT_ASSERT_NOW(a_single_op, qreq_i.push, !qreq_i.pop, "push and pop in one cycle")
  `SWT_ASSERT_NEXT(a_pop_count, qreq_i.pop, count_q == $past(count_q) - 1'b1, "pop count slip")

endmodule

/* rtl/core/swt_ctrl.sv */
`timescale 1ns / 1ps

module swt_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_idx_i,
  input  logic [15:0]         cfg_data_i,
  input  logic                accept_i,
  input  logic [1:0]          operation_i,
  input  logic [7:0]          req_dst_i,
  input  logic                req_has_payload_i,
  input  logic [31:0]         payload_i,
  input  logic                rx_bit_error_i,
  input  logic [7:0]          rx_dst_i,
  input  logic [7:0]          rx_src_i,
  input  logic                rx_is_ack_i,
  input  logic [15:0]         rx_seq_i,
  input  swt_pkg::qstat_t     qstat_i,
  output swt_pkg::qreq_t      qreq_o,
  output logic                item_valid_o,
  output swt_pkg::item_t      item_o,
  output swt_pkg::view_t      view_o,
  output swt_pkg::cfg_t       cfg_o
);

  swt_pkg::cfg_t   cfg_q, cfg_d;
  logic            waiting_q, waiting_d;
  logic [15:0]     send_seq_q, send_seq_d;
  logic [15:0]     expect_seq_q, expect_seq_d;
  logic [15:0]     timer_left_q, timer_left_d;
  logic            armed_q, armed_d;
  swt_pkg::entry_t last_q, last_d;
  logic            last_mem_q, last_mem_d;

  swt_pkg::op_e    op;
  logic            own_bad;
  logic            dst_bad;
  logic            queue_full;
  swt_pkg::lim_t   limit;
  logic [15:0]     next_seq;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (swt_pkg::cfg_idx_e'(cfg_idx_i))
        swt_pkg::CFG_OWN_ADDR:      cfg_d.own_addr      = cfg_data_i[7:0];
        swt_pkg::CFG_ADDR_LOW:      cfg_d.addr_low      = cfg_data_i[7:0];
        swt_pkg::CFG_ADDR_HIGH:     cfg_d.addr_high     = cfg_data_i[7:0];
        swt_pkg::CFG_TIMEOUT_TICKS: cfg_d.timeout_ticks = cfg_data_i;
        swt_pkg::CFG_QUEUE_LIMIT:   cfg_d.queue_limit   = cfg_data_i[5:0];
        swt_pkg::CFG_HEADER_BITS:   cfg_d.header_bits   = cfg_data_i;
        swt_pkg::CFG_ACK_BITS:      cfg_d.ack_bits      = cfg_data_i;
        swt_pkg::CFG_UP_CONNECTED:  cfg_d.up_connected  = cfg_data_i[0];
      endcase
    end
  end

  assign op       = swt_pkg::op_e'(operation_i);
  assign own_bad  = (cfg_q.own_addr < cfg_q.addr_low) || (cfg_q.own_addr > cfg_q.addr_high);
  assign dst_bad  = (req_dst_i < cfg_q.addr_low) || (req_dst_i > cfg_q.addr_high);
  assign next_seq = expect_seq_q + 16'd1;

  always_comb begin
    if (cfg_q.queue_limit[5]) begin
      limit = swt_pkg::QLIM_DEPTH;
    end else if (swt_pkg::lim_t'(cfg_q.queue_limit) > swt_pkg::QLIM_DEPTH) begin
      limit = swt_pkg::QLIM_DEPTH;
    end else begin
      limit = swt_pkg::lim_t'(cfg_q.queue_limit);
    end
  end

  assign queue_full = swt_pkg::lim_t'(qstat_i.count) >= limit;

  always_comb begin
    waiting_d    = waiting_q;
    send_seq_d   = send_seq_q;
    expect_seq_d = expect_seq_q;
    timer_left_d = timer_left_q;
    armed_d      = armed_q;
    last_d       = last_q;
    last_mem_d   = last_mem_q;
    qreq_o       = '0;
    item_valid_o = 1'b0;
    item_o       = '0;
    item_o.src     = rx_src_i;
    item_o.seq     = rx_seq_i;
    item_o.payload = payload_i;

    if (accept_i && (op != swt_pkg::OP_NONE)) begin
      if (own_bad) begin
        item_valid_o  = 1'b1;
        item_o.code   = swt_pkg::ITEM_DROP;
        item_o.reason = swt_pkg::DROP_BAD_OWN;
      end else begin
        unique case (op)
          swt_pkg::OP_TICK: begin
            if (armed_q) begin
              if (timer_left_q <= 16'd1) begin
                item_valid_o = 1'b1;
                item_o.code  = swt_pkg::ITEM_DATA;
                timer_left_d = cfg_q.timeout_ticks;
                armed_d      = 1'b1;
                waiting_d    = 1'b1;
              end else begin
                timer_left_d = timer_left_q - 16'd1;
              end
            end
          end
          swt_pkg::OP_SEND: begin
            if (dst_bad) begin
              item_valid_o  = 1'b1;
              item_o.code   = swt_pkg::ITEM_DROP;
              item_o.reason = swt_pkg::DROP_BAD_DEST;
            end else if (!req_has_payload_i) begin
              item_valid_o  = 1'b1;
              item_o.code   = swt_pkg::ITEM_DROP;
              item_o.reason = swt_pkg::DROP_NO_PAYLOAD;
            end else if (!waiting_q) begin
              item_valid_o   = 1'b1;
              item_o.code    = swt_pkg::ITEM_DATA;
              send_seq_d     = send_seq_q + 16'd1;
              last_d.dst     = req_dst_i;
              last_d.payload = payload_i;
              last_mem_d     = 1'b0;
              timer_left_d   = cfg_q.timeout_ticks;
              armed_d        = 1'b1;
              waiting_d      = 1'b1;
            end else if (queue_full) begin
              item_valid_o  = 1'b1;
              item_o.code   = swt_pkg::ITEM_DROP;
              item_o.reason = swt_pkg::DROP_QUEUE_FULL;
            end else begin
              qreq_o.push          = 1'b1;
              qreq_o.wdata.dst     = req_dst_i;
              qreq_o.wdata.payload = payload_i;
            end
          end
          swt_pkg::OP_FRAME: begin
            if (rx_bit_error_i) begin
              item_valid_o  = 1'b1;
              item_o.code   = swt_pkg::ITEM_DROP;
              item_o.reason = swt_pkg::DROP_BIT_ERROR;
            end else if (rx_dst_i != cfg_q.own_addr) begin
              item_valid_o  = 1'b1;
              item_o.code   = swt_pkg::ITEM_DROP;
              item_o.reason = swt_pkg::DROP_NOT_OURS;
            end else if (rx_is_ack_i) begin
              if (rx_seq_i == send_seq_q) begin
                armed_d      = 1'b0;
                timer_left_d = '0;
                if (qstat_i.count == '0) begin
                  waiting_d = 1'b0;
                end else begin
                  // The popped entry becomes the kept frame once the read returns.
                  qreq_o.pop   = 1'b1;
                  item_valid_o = 1'b1;
                  item_o.code  = swt_pkg::ITEM_DATA;
                  send_seq_d   = send_seq_q + 16'd1;
                  last_mem_d   = 1'b1;
                  timer_left_d = cfg_q.timeout_ticks;
                  armed_d      = 1'b1;
                  waiting_d    = 1'b1;
                end
              end
            end else if (rx_seq_i == next_seq) begin
              expect_seq_d   = next_seq;
              item_valid_o   = 1'b1;
              item_o.code    = swt_pkg::ITEM_ACK;
              item_o.deliver = cfg_q.up_connected;
            end else if (rx_seq_i <= expect_seq_q) begin
              item_valid_o = 1'b1;
              item_o.code  = swt_pkg::ITEM_ACK;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.own_addr      <= '0;
      cfg_q.addr_low      <= '0;
      cfg_q.addr_high     <= swt_pkg::RST_ADDR_HIGH;
      cfg_q.timeout_ticks <= swt_pkg::RST_TIMEOUT;
      cfg_q.queue_limit   <= swt_pkg::RST_QUEUE_LIMIT;
      cfg_q.header_bits   <= '0;
      cfg_q.ack_bits      <= swt_pkg::RST_ACK_BITS;
      cfg_q.up_connected  <= 1'b1;
      waiting_q           <= 1'b0;
      send_seq_q          <= '0;
      expect_seq_q        <= '0;
      timer_left_q        <= '0;
      armed_q             <= 1'b0;
      last_q              <= '0;
      last_mem_q          <= 1'b0;
    end else begin
      cfg_q        <= cfg_d;
      waiting_q    <= waiting_d;
      send_seq_q   <= send_seq_d;
      expect_seq_q <= expect_seq_d;
      timer_left_q <= timer_left_d;
      armed_q      <= armed_d;
      last_q       <= last_d;
      last_mem_q   <= last_mem_d;
    end
  end

  assign view_o.send_seq   = send_seq_q;
  assign view_o.expect_seq = expect_seq_q;
  assign view_o.last       = last_mem_q ? qstat_i.rdata : last_q;
  assign cfg_o             = cfg_q;

endmodule

/* rtl/core/swt_out.sv */
`timescale 1ns / 1ps

module swt_out (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                item_valid_i,
  input  swt_pkg::item_t      item_i,
  input  swt_pkg::view_t      view_i,
  input  swt_pkg::cfg_t       cfg_i,
  input  logic                out_stall_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  output swt_pkg::result_t    res_o
);

  logic             p_valid_q;
  swt_pkg::item_t   p_item_q;
  logic             p_idx_q;
  logic             o_valid_q;
  swt_pkg::result_t o_res_q;

  swt_pkg::result_t res0;
  swt_pkg::result_t res1;
  swt_pkg::result_t cur;
  logic             two;
  logic             o_free;
  logic             p_move;
  logic             p_done;

  always_comb begin
    res0        = '0;
    res0.kind   = swt_pkg::KIND_DROP;
    res0.reason = p_item_q.reason;
    unique case (p_item_q.code)
      swt_pkg::ITEM_DATA: begin
        res0.kind    = swt_pkg::KIND_DATA;
        res0.seq     = view_i.send_seq;
        res0.src     = cfg_i.own_addr;
        res0.dst     = view_i.last.dst;
        res0.hop     = swt_pkg::mod10(view_i.last.dst);
        res0.payload = view_i.last.payload;
        res0.bits    = cfg_i.header_bits;
        res0.reason  = swt_pkg::DROP_NONE;
      end
      swt_pkg::ITEM_ACK: begin
        res0.kind   = swt_pkg::KIND_ACK;
        res0.seq    = view_i.expect_seq;
        res0.src    = cfg_i.own_addr;
        res0.dst    = p_item_q.src;
        res0.hop    = swt_pkg::mod10(p_item_q.src);
        res0.bits   = cfg_i.ack_bits;
        res0.reason = swt_pkg::DROP_NONE;
      end
      default: begin
      end
    endcase

    res1         = '0;
    res1.kind    = swt_pkg::KIND_DELIVER;
    res1.seq     = p_item_q.seq;
    res1.src     = p_item_q.src;
    res1.dst     = cfg_i.own_addr;
    res1.payload = p_item_q.payload;
    res1.reason  = swt_pkg::DROP_NONE;

    two      = (p_item_q.code == swt_pkg::ITEM_ACK) && p_item_q.deliver;
    cur      = p_idx_q ? res1 : res0;
    cur.last = p_idx_q || !two;
  end

  assign o_free     = !o_valid_q || !out_stall_i;
  assign p_move     = p_valid_q && o_free;
  assign p_done     = p_move && cur.last;
  assign in_stall_o = p_valid_q && !p_done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_valid_q <= 1'b0;
      p_idx_q   <= 1'b0;
      o_valid_q <= 1'b0;
    end else begin
      if (item_valid_i) begin
        p_valid_q <= 1'b1;
        p_idx_q   <= 1'b0;
      end else if (p_done) begin
        p_valid_q <= 1'b0;
      end else if (p_move) begin
        p_idx_q <= 1'b1;
      end
      if (p_move) begin
        o_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        o_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_valid_i) begin
      p_item_q <= item_i;
    end
    if (p_move) begin
      o_res_q <= cur;
    end
  end

  assign out_valid_o = o_valid_q;
  assign res_o       = o_res_q;

endmodule

/* rtl/core/stop_and_wait_transport.sv */
// Channel   Direction  Handshake                 Word
// input     in         in_valid_i / in_stall_o   operation and request or frame fields
// output    out        out_valid_o / out_stall_i kind, seq, addresses, payload, reason, last
// config    in         cfg_we_i                  cfg_idx_i, cfg_data_i
//
// One input word is taken per cycle unless the output stalls; a word that yields an ACK
// and a delivery holds the input while the ACK moves, as the output register moves one
// word per cycle. A result passes the pending register, then the output register; the
// memory is read at the accepting edge and the result is formed from its registered data.
// Reset is asynchronous and needs no clearing pass; queue entries are unset until written.
// in_stall_o rises while a formed result cannot move into a stalled output register,
// and for the cycle in which the ACK of an ACK and delivery pair moves.
`timescale 1ns / 1ps

module stop_and_wait_transport (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  operation_i,
  input  logic [7:0]  req_dst_i,
  input  logic        req_has_payload_i,
  input  logic [31:0] payload_i,
  input  logic        rx_bit_error_i,
  input  logic [7:0]  rx_dst_i,
  input  logic [7:0]  rx_src_i,
  input  logic        rx_is_ack_i,
  input  logic [15:0] rx_seq_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  kind_o,
  output logic [15:0] seq_o,
  output logic [7:0]  src_addr_o,
  output logic [7:0]  dst_addr_o,
  output logic [3:0]  next_hop_o,
  output logic [31:0] out_payload_o,
  output logic [15:0] frame_bits_o,
  output logic [2:0]  drop_reason_o,
  output logic        last_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i
);

  logic             accept;
  swt_pkg::qreq_t   qreq;
  swt_pkg::qstat_t  qstat;
  logic             item_valid;
  swt_pkg::item_t   item;
  swt_pkg::view_t   view;
  swt_pkg::cfg_t    cfg;
  swt_pkg::result_t res;

  assign accept = in_valid_i && !in_stall_o;

  swt_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .qreq_i  (qreq),
    .qstat_o (qstat)
  );

  swt_ctrl u_ctrl (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_data_i        (cfg_data_i),
    .accept_i          (accept),
    .operation_i       (operation_i),
    .req_dst_i         (req_dst_i),
    .req_has_payload_i (req_has_payload_i),
    .payload_i         (payload_i),
    .rx_bit_error_i    (rx_bit_error_i),
    .rx_dst_i          (rx_dst_i),
    .rx_src_i          (rx_src_i),
    .rx_is_ack_i       (rx_is_ack_i),
    .rx_seq_i          (rx_seq_i),
    .qstat_i           (qstat),
    .qreq_o            (qreq),
    .item_valid_o      (item_valid),
    .item_o            (item),
    .view_o            (view),
    .cfg_o             (cfg)
  );

  swt_out u_out (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_i       (item),
    .view_i       (view),
    .cfg_i        (cfg),
    .out_stall_i  (out_stall_i),
    .in_stall_o   (in_stall_o),
    .out_valid_o  (out_valid_o),
    .res_o        (res)
  );

  assign kind_o        = res.kind;
  assign seq_o         = res.seq;
  assign src_addr_o    = res.src;
  assign dst_addr_o    = res.dst;
  assign next_hop_o    = res.hop;
  assign out_payload_o = res.payload;
  assign frame_bits_o  = res.bits;
  assign drop_reason_o = res.reason;
  assign last_o        = res.last;

endmodule
